// ===== sv/cma_pkg.sv =====
package cma_pkg;

  // command codes
  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // field widths fixed by the interface
  localparam int CLASS_W = 5;
  localparam int OUT_W   = 32;
  localparam int PCT_W   = 14;

  // percentage scale (hundredths of a percent) and division step counter
  localparam int PCT_SCALE = 10000;
  localparam int DIV_CNT_W = $clog2(PCT_W);

  // class count after reset
  localparam logic [CLASS_W-1:0] NUM_CLASSES_RST = 5'd16;

  typedef struct packed {
    logic               cmd;
    logic [CLASS_W-1:0] true_class;
    logic [CLASS_W-1:0] assigned_class;
    logic [CLASS_W-1:0] read_row;
    logic [CLASS_W-1:0] read_col;
  } in_word_t;

  typedef struct packed {
    logic [OUT_W-1:0] cell_count;
    logic [OUT_W-1:0] row_total;
    logic [PCT_W-1:0] percent_hundredths;
    logic             class_error;
  } out_word_t;

endpackage

// ===== sv/confusion_matrix_accumulator_core.sv =====
// Accumulate words: one per cycle while not busy, read-modify-write through registered-read
// memories with forwarding; an out-of-range accumulate's error word goes via stage 1 to the output.
// Read words: busy through memory read, multiply and a 14-step restoring divider;
// error reads and empty-row reads go from stage 1 to the output. No stall from the receiver.
// Reset (rst_n low, synchronous) starts a clearing pass over all (MAX_CLASSES+1)^2 cells, one
// a cycle with row totals alongside the first ones; busy is high meanwhile; cfg writes still taken.
module confusion_matrix_accumulator_core #(
  parameter int MAX_CLASSES = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  cma_pkg::in_word_t                    in_word,
  output logic                                 out_valid,
  output cma_pkg::out_word_t                   out_word,
  input  logic                                 cfg_we,
  input  logic [cma_pkg::CLASS_W-1:0]          cfg_wdata
);

  localparam int DIM   = MAX_CLASSES + 1;
  localparam int DEPTH = DIM * DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(DIM);
  localparam int CLW   = $clog2(DIM);
  localparam int CMPW  = (CLW > cma_pkg::CLASS_W) ? CLW : cma_pkg::CLASS_W;
  localparam int CW    = COUNT_WIDTH;
  localparam int PW    = CW + cma_pkg::PCT_W;
  localparam int EW    = (CW > cma_pkg::OUT_W) ? CW : cma_pkg::OUT_W;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_MUL   = 4'b0100,
    ST_DIV   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [cma_pkg::CLASS_W-1:0] num_classes_r;
  logic [CMPW-1:0]             n_eff;

  // memories
  logic [CW-1:0] cell_mem [DEPTH];
  logic [CW-1:0] row_mem  [DIM];
  logic [CW-1:0] cell_rdata_r, row_rdata_r;
  logic [AW-1:0] rd_cell_addr, cell_waddr;
  logic [RW-1:0] rd_row_addr, row_waddr;
  logic          cell_we, row_we;
  logic [CW-1:0] cell_wdata, row_wdata;

  // clearing pass
  logic [AW-1:0] clr_cnt_r;
  logic          clearing;

  // stage 1
  logic          s1_valid_r, s1_rd_r, s1_err_r, s1_wr_r;
  logic [AW-1:0] s1_cell_addr_r;
  logic [RW-1:0] s1_row_addr_r;
  logic [CW-1:0] cell_cur, row_cur;

  // forwarding of the last write
  logic          fwd_valid_r;
  logic [AW-1:0] fwd_cell_addr_r;
  logic [RW-1:0] fwd_row_addr_r;
  logic [CW-1:0] fwd_cell_r, fwd_row_r;

  // divider
  logic [CW-1:0]                 cell_hold_r, total_hold_r;
  logic [PW-1:0]                 prod_r, num;
  logic [CW-1:0]                 rem_r;
  logic [cma_pkg::PCT_W-1:0]     dvd_lo_r, q_r, q_fin;
  logic [cma_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [CW:0]                   trial, diff;
  logic                          ge, div_last;

  // stage 0 decode
  logic                        accept, in_bad, in_is_read;
  logic [cma_pkg::CLASS_W-1:0] sel_row, sel_col;

  // output
  logic                      out_valid_nxt;
  logic                      out_err_nxt;
  logic [CW-1:0]             out_cell_src, out_total_src;
  logic [cma_pkg::PCT_W-1:0] out_pct_nxt;
  logic [EW-1:0]             cell_ext, total_ext;
  logic                      out_valid_r;
  cma_pkg::out_word_t        out_word_r;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_classes_r <= cma_pkg::NUM_CLASSES_RST;
    end else if (cfg_we) begin
      num_classes_r <= cfg_wdata;
    end
  end

  assign n_eff = (CMPW'(num_classes_r) > CMPW'(MAX_CLASSES)) ? CMPW'(MAX_CLASSES)
                                                              : CMPW'(num_classes_r);

  // input decode and read addresses
  assign clearing   = (state_r == ST_CLEAR);
  assign busy       = (state_r != ST_IDLE) || (s1_valid_r && s1_rd_r);
  assign accept     = start && !busy;
  assign in_is_read = (in_word.cmd == cma_pkg::CMD_READ);
  assign sel_row    = in_is_read ? in_word.read_row : in_word.true_class;
  assign sel_col    = in_is_read ? in_word.read_col : in_word.assigned_class;
  assign in_bad     = (CMPW'(sel_row) > n_eff) || (CMPW'(sel_col) > n_eff);

  assign rd_cell_addr = AW'(sel_row) * AW'(DIM) + AW'(sel_col);
  assign rd_row_addr  = RW'(sel_row);

  // stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_rd_r    <= 1'b0;
      s1_err_r   <= 1'b0;
      s1_wr_r    <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      s1_rd_r    <= in_is_read;
      if (in_is_read) begin
        s1_err_r <= in_bad;
        s1_wr_r  <= 1'b0;
      end else begin
        s1_err_r <= (in_word.true_class != '0) && in_bad;
        s1_wr_r  <= (in_word.true_class != '0) && !in_bad;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_cell_addr_r <= rd_cell_addr;
    s1_row_addr_r  <= rd_row_addr;
  end

  // read data with forwarding of the write from the previous cycle
  assign cell_cur = (fwd_valid_r && fwd_cell_addr_r == s1_cell_addr_r) ? fwd_cell_r
                                                                        : cell_rdata_r;
  assign row_cur  = (fwd_valid_r && fwd_row_addr_r == s1_row_addr_r) ? fwd_row_r
                                                                      : row_rdata_r;

  // write port: clearing pass or saturating increment
  assign cell_we    = clearing || (s1_valid_r && s1_wr_r);
  assign row_we     = (clearing && clr_cnt_r < AW'(DIM)) || (s1_valid_r && s1_wr_r);
  assign cell_waddr = clearing ? clr_cnt_r : s1_cell_addr_r;
  assign row_waddr  = clearing ? RW'(clr_cnt_r) : s1_row_addr_r;
  assign cell_wdata = clearing ? '0 : ((cell_cur == '1) ? cell_cur : cell_cur + 1'b1);
  assign row_wdata  = clearing ? '0 : ((row_cur == '1) ? row_cur : row_cur + 1'b1);

  // cell count memory
  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    cell_rdata_r <= cell_mem[rd_cell_addr];
  end

  // row total memory
  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    row_rdata_r <= row_mem[rd_row_addr];
  end

  // forwarding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else begin
      fwd_valid_r <= s1_valid_r && s1_wr_r;
    end
  end

  always_ff @(posedge clk) begin
    fwd_cell_addr_r <= s1_cell_addr_r;
    fwd_row_addr_r  <= s1_row_addr_r;
    fwd_cell_r      <= cell_wdata;
    fwd_row_r       <= row_wdata;
  end

  // clearing counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (clearing) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // read sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s1_valid_r && s1_rd_r && !s1_err_r && row_cur != '0) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // restoring divider step
  assign num      = prod_r + PW'(total_hold_r >> 1);
  assign trial    = {rem_r, dvd_lo_r[cma_pkg::PCT_W-1]};
  assign diff     = trial - {1'b0, total_hold_r};
  assign ge       = (trial >= {1'b0, total_hold_r});
  assign div_last = (div_cnt_r == cma_pkg::DIV_CNT_W'(cma_pkg::PCT_W - 1));
  assign q_fin    = {q_r[cma_pkg::PCT_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      cell_hold_r  <= cell_cur;
      total_hold_r <= row_cur;
      prod_r       <= PW'(cell_cur) * PW'(cma_pkg::PCT_SCALE);
    end
    if (state_r == ST_MUL) begin
      rem_r     <= num[PW-1:cma_pkg::PCT_W];
      dvd_lo_r  <= num[cma_pkg::PCT_W-1:0];
      q_r       <= '0;
      div_cnt_r <= '0;
    end else if (state_r == ST_DIV) begin
      rem_r     <= ge ? diff[CW-1:0] : trial[CW-1:0];
      dvd_lo_r  <= {dvd_lo_r[cma_pkg::PCT_W-2:0], 1'b0};
      q_r       <= q_fin;
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  // result select
  always_comb begin
    out_valid_nxt = 1'b0;
    out_err_nxt   = 1'b0;
    out_cell_src  = '0;
    out_total_src = '0;
    out_pct_nxt   = '0;
    priority if (state_r == ST_DIV && div_last) begin
      out_valid_nxt = 1'b1;
      out_cell_src  = cell_hold_r;
      out_total_src = total_hold_r;
      out_pct_nxt   = (q_fin > cma_pkg::PCT_W'(cma_pkg::PCT_SCALE))
                      ? cma_pkg::PCT_W'(cma_pkg::PCT_SCALE) : q_fin;
    end else if (s1_valid_r && s1_err_r) begin
      out_valid_nxt = 1'b1;
      out_err_nxt   = 1'b1;
    end else if (s1_valid_r && s1_rd_r && row_cur == '0) begin
      out_valid_nxt = 1'b1;
      out_cell_src  = cell_cur;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  // clip wide counts to the output width
  assign cell_ext  = EW'(out_cell_src);
  assign total_ext = EW'(out_total_src);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r.cell_count <= (cell_ext > EW'({cma_pkg::OUT_W{1'b1}}))
                             ? {cma_pkg::OUT_W{1'b1}} : cell_ext[cma_pkg::OUT_W-1:0];
    out_word_r.row_total  <= (total_ext > EW'({cma_pkg::OUT_W{1'b1}}))
                             ? {cma_pkg::OUT_W{1'b1}} : total_ext[cma_pkg::OUT_W-1:0];
    out_word_r.percent_hundredths <= out_pct_nxt;
    out_word_r.class_error        <= out_err_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // checks
  a_read_holds_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_word.cmd == cma_pkg::CMD_READ) |=> busy)
    else $error("read word accepted without raising busy");

  a_no_write_during_div: assert property (@(posedge clk) disable iff (!rst_n)
    !((state_r == ST_DIV || state_r == ST_MUL) && s1_valid_r && s1_wr_r))
    else $error("accumulate in flight while dividing");

  a_cell_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.class_error) |-> (out_word.cell_count <= out_word.row_total))
    else $error("cell count above row total");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.percent_hundredths <= cma_pkg::PCT_W'(cma_pkg::PCT_SCALE)))
    else $error("percentage out of range");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;

  localparam int N_CLS   = 16;
  localparam int CNT_W   = 32;
  localparam int IN_W    = $bits(cma_pkg::in_word_t);
  localparam int DRAIN   = 24;
  localparam int N_ITEMS = 1150;

  // confusion matrix bookkeeping and expected readout words
  class cm_scoreboard;
    longint unsigned    cells [0:N_CLS][0:N_CLS];
    longint unsigned    totals [0:N_CLS];
    int unsigned        classes;
    int unsigned        mismatches;
    cma_pkg::out_word_t expected_q[$];

    function new();
      classes    = 16;
      mismatches = 0;
      foreach (cells[i, j]) cells[i][j] = 0;
      foreach (totals[i]) totals[i] = 0;
    endfunction

    function void set_classes(int unsigned v);
      classes = v;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function longint unsigned bump(longint unsigned v);
      longint unsigned top;
      top = (64'd1 << CNT_W) - 64'd1;
      return (v >= top) ? top : v + 64'd1;
    endfunction

    // accepted input word: update counts, queue the readout or error word
    function void note_word(cma_pkg::in_word_t w);
      cma_pkg::out_word_t r;
      int unsigned        n, x, y;
      longint unsigned    cnt, tot, pct;
      n = (classes > N_CLS) ? N_CLS : classes;
      r = '0;
      if (w.cmd == cma_pkg::CMD_ACCUM) begin
        x = int'(w.true_class);
        y = int'(w.assigned_class);
        // pixel outside every test area
        if (x == 0) return;
        if (x > n || y > n) begin
          r.class_error = 1'b1;
          expected_q.push_back(r);
          return;
        end
        cells[x][y] = bump(cells[x][y]);
        totals[x]   = bump(totals[x]);
      end else begin
        x = int'(w.read_row);
        y = int'(w.read_col);
        if (x > n || y > n) begin
          r.class_error = 1'b1;
          expected_q.push_back(r);
          return;
        end
        cnt = cells[x][y];
        tot = totals[x];
        pct = 0;
        // row-normalized share, rounded to nearest
        if (tot != 0) begin
          pct = (cnt * 64'd10000 + tot / 64'd2) / tot;
          if (pct > 64'd10000) pct = 64'd10000;
        end
        r.cell_count         = cma_pkg::OUT_W'((cnt > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : cnt);
        r.row_total          = cma_pkg::OUT_W'((tot > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : tot);
        r.percent_hundredths = cma_pkg::PCT_W'(pct);
        expected_q.push_back(r);
      end
    endfunction

    function void report(string what, cma_pkg::out_word_t want, cma_pkg::out_word_t got);
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch, %s: expected cell %0d total %0d pct %0d err %0b,",
                  " got cell %0d total %0d pct %0d err %0b"},
                 what, want.cell_count, want.row_total, want.percent_hundredths,
                 want.class_error, got.cell_count, got.row_total,
                 got.percent_hundredths, got.class_error);
    endfunction

    // result word: compare against the oldest expectation
    function void check_word(cma_pkg::out_word_t got);
      cma_pkg::out_word_t want;
      if (expected_q.size() == 0) begin
        report("unexpected word", '0, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.cell_count !== want.cell_count || got.row_total !== want.row_total ||
          got.percent_hundredths !== want.percent_hundredths ||
          got.class_error !== want.class_error)
        report("field differs", want, got);
    endfunction
  endclass

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        start     = 1'b0;
  logic                        busy;
  cma_pkg::in_word_t           in_word   = '0;
  logic                        out_valid;
  cma_pkg::out_word_t          out_word;
  logic                        cfg_we    = 1'b0;
  logic [cma_pkg::CLASS_W-1:0] cfg_wdata = '0;

  cm_scoreboard sb;

  confusion_matrix_accumulator_core #(
    .MAX_CLASSES(N_CLS),
    .COUNT_WIDTH(CNT_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_word(out_word),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // watch both handshakes at each rising edge
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1) sb.check_word(out_word);
      if (start === 1'b1 && busy === 1'b0) sb.note_word(in_word);
    end
  end

  // one word, after an optional gap; returns at the accepting edge
  task automatic send_word(cma_pkg::in_word_t w, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic write_classes(int unsigned v);
    cfg_we    <= 1'b1;
    cfg_wdata <= cma_pkg::CLASS_W'(v);
    @(posedge clk);
    sb.set_classes(v);
    cfg_we    <= 1'b0;
  endtask

  // hold off until every expected word is back and the pipeline is empty
  task automatic settle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic cma_pkg::in_word_t mk(logic cmd, int unsigned x, int unsigned y);
    logic [IN_W-1:0]   raw;
    cma_pkg::in_word_t w;
    raw = IN_W'($urandom);
    w   = raw;
    w.cmd = cmd;
    if (cmd == cma_pkg::CMD_ACCUM) begin
      w.true_class     = cma_pkg::CLASS_W'(x);
      w.assigned_class = cma_pkg::CLASS_W'(y);
    end else begin
      w.read_row = cma_pkg::CLASS_W'(x);
      w.read_col = cma_pkg::CLASS_W'(y);
    end
    return w;
  endfunction

  // mostly in-range pixels with some readouts, plus zero-class and noise words
  function automatic cma_pkg::in_word_t rand_word(int unsigned n);
    logic [IN_W-1:0]   raw;
    cma_pkg::in_word_t w;
    int unsigned       k;
    raw = IN_W'($urandom);
    w   = raw;
    k   = $urandom_range(0, 99);
    if (k < 80) begin
      if (n > 0 && k < 70) begin
        w = mk(cma_pkg::CMD_ACCUM, $urandom_range(1, n), $urandom_range(0, n));
      end else if (k < 74) begin
        w = mk(cma_pkg::CMD_ACCUM, 0, $urandom_range(0, 31));
      end else begin
        w.cmd = cma_pkg::CMD_ACCUM;
      end
    end else begin
      if (k < 96) w = mk(cma_pkg::CMD_READ, $urandom_range(0, n), $urandom_range(0, n));
      else w.cmd = cma_pkg::CMD_READ;
    end
    return w;
  endfunction

  initial begin
    cma_pkg::in_word_t directed[$];
    int unsigned       phase_cls[$];
    int unsigned       per_phase, n, gap, calm_left;

    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corner classes, zero class, out-of-range, rounding, empty rows
    directed = '{mk(cma_pkg::CMD_ACCUM, 1, 0), mk(cma_pkg::CMD_ACCUM, 1, 1),
                 mk(cma_pkg::CMD_ACCUM, 16, 16), mk(cma_pkg::CMD_ACCUM, 16, 0),
                 mk(cma_pkg::CMD_ACCUM, 0, 5), mk(cma_pkg::CMD_ACCUM, 17, 1),
                 mk(cma_pkg::CMD_ACCUM, 1, 17), mk(cma_pkg::CMD_ACCUM, 31, 31),
                 mk(cma_pkg::CMD_ACCUM, 3, 3), mk(cma_pkg::CMD_ACCUM, 3, 3),
                 mk(cma_pkg::CMD_ACCUM, 3, 3), mk(cma_pkg::CMD_ACCUM, 3, 4),
                 mk(cma_pkg::CMD_ACCUM, 4, 1), mk(cma_pkg::CMD_ACCUM, 4, 1),
                 mk(cma_pkg::CMD_ACCUM, 4, 2),
                 mk(cma_pkg::CMD_READ, 1, 0), mk(cma_pkg::CMD_READ, 3, 3),
                 mk(cma_pkg::CMD_READ, 3, 4), mk(cma_pkg::CMD_READ, 4, 1),
                 mk(cma_pkg::CMD_READ, 16, 16), mk(cma_pkg::CMD_READ, 0, 0),
                 mk(cma_pkg::CMD_READ, 2, 3), mk(cma_pkg::CMD_READ, 17, 0),
                 mk(cma_pkg::CMD_READ, 1, 31)};
    foreach (directed[i]) send_word(directed[i], (i % 3 == 0) ? 0 : $urandom_range(0, 4));
    settle();

    // random phases over several class counts, extremes included
    phase_cls = '{1, 0, 31, 17, 7, 2, 16, $urandom_range(0, 31)};
    per_phase = N_ITEMS / phase_cls.size();
    calm_left = 0;
    foreach (phase_cls[p]) begin
      write_classes(phase_cls[p]);
      n = (phase_cls[p] > N_CLS) ? N_CLS : phase_cls[p];
      for (int unsigned i = 0; i < per_phase; i++) begin
        if (calm_left > 0) begin
          gap = 0;
          calm_left--;
        end else begin
          gap = $urandom_range(0, 18);
          if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(10, 40);
        end
        send_word(rand_word(n), gap);
      end
      settle();
    end

    repeat (DRAIN) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // run limit
  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
